@@ rtl/gpps_pkg.sv @@
package gpps_pkg;

    // Map depth and the address width that follows from it
    localparam int SIZE   = 1048576;
    localparam int MAP_AW = $clog2(SIZE);

    // Field widths of the stream words
    localparam int VALUE_W     = 20;
    localparam int WALK_W      = VALUE_W + 1;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;

    // True when an index lies inside the map; outside reads as not prime
    function automatic logic in_map(input logic [WALK_W-1:0] idx);
        in_map = (32'(idx) < 32'(SIZE));
    endfunction

    // Map address of a walk index
    function automatic logic [MAP_AW-1:0] map_addr(input logic [WALK_W-1:0] idx);
        map_addr = MAP_AW'(idx);
    endfunction

endpackage

@@ rtl/goldbach_prime_pair_search.sv @@
// Channel   Dir  Word                                       Handshake
// s_axis    in   query_value [19:0]                         tvalid & tready
// m_axis    out  found [0], smaller [20:1], larger [40:21]  tvalid & tready
//
// After reset the map is filled, then multiples of each prime p with p*p < SIZE are
// cleared one map bit a cycle; s_axis_tready stays low throughout. A query then answers
// n <= 4 without a map read, checks only 2 + (n-2) for odd n, and for even n walks the
// pairs from n/2 up until one is found or none is left; each
// step reads both map bits of a pair through the two read ports of the map memory.
// A stalled result holds in the output register; the next word is still taken and its
// result holds in the finishing state until the register frees.
module goldbach_prime_pair_search
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [19:0] query_value, zero fill above
    input  logic [gpps_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [0] found, [20:1] smaller_prime, [40:21] larger_prime, zero fill above
    output logic [gpps_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    localparam int AW = gpps_pkg::MAP_AW;
    localparam int VW = gpps_pkg::VALUE_W;
    localparam int WW = gpps_pkg::WALK_W;

    localparam logic [2:0] S_FILL  = 3'd0;
    localparam logic [2:0] S_PREAD = 3'd1;
    localparam logic [2:0] S_PCHK  = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_IDLE  = 3'd4;
    localparam logic [2:0] S_ODD   = 3'd5;
    localparam logic [2:0] S_WALK  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic [AW:0] SIZE_C = (AW+1)'(gpps_pkg::SIZE);

    logic [2:0]    state_reg, state_next;

    // Sieve counters: m doubles as the fill address
    logic [AW:0]   m_reg, m_next;
    logic [AW-1:0] p_reg, p_next;
    logic [AW:0]   psq_reg, psq_next;

    // Query walk
    logic [VW-1:0] n_reg, n_next;
    logic [WW-1:0] i_reg, i_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [WW-1:0] chk_i_reg, chk_i_next;

    // Finished result and output register
    logic          res_found_reg, res_found_next;
    logic [VW-1:0] res_lo_reg, res_lo_next;
    logic [VW-1:0] res_hi_reg, res_hi_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_found_reg, out_found_next;
    logic [VW-1:0] out_lo_reg, out_lo_next;
    logic [VW-1:0] out_hi_reg, out_hi_next;

    // Map memory: one write port, two registered read ports
    logic          map_mem [gpps_pkg::SIZE];
    logic          map_we;
    logic [AW-1:0] map_waddr;
    logic          map_wdata;
    logic [AW-1:0] rd_addr_a, rd_addr_b;
    logic          rd_a_reg, rd_b_reg;

    logic          in_acc;
    logic [VW-1:0] q_in;
    logic [WW-1:0] half_in, start_in, odd_idx, n_wide, chk_j, pair_j;
    logic          hit, issue, load_out;
    logic [AW:0]   m_step;

    assign q_in     = s_axis_tdata[VW-1:0];
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign half_in  = WW'(q_in >> 1);
    assign start_in = half_in[0] ? half_in : half_in + WW'(1);
    assign n_wide   = WW'(n_reg);
    assign odd_idx  = n_wide - WW'(2);
    assign chk_j    = n_wide - chk_i_reg;
    assign pair_j   = n_wide - i_reg;
    assign issue    = (i_reg <= n_wide);
    assign m_step   = m_reg + (AW+1)'(p_reg);
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);

    assign hit = chk_valid_reg && rd_a_reg && rd_b_reg
                 && gpps_pkg::in_map(chk_i_reg) && gpps_pkg::in_map(chk_j)
                 && (chk_i_reg > chk_j);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(gpps_pkg::OUT_TDATA_W - 2*VW - 1)'(0),
                            out_hi_reg, out_lo_reg, out_found_reg};

    // Memory write and read address selection
    always_comb
    begin
        map_we    = 1'b0;
        map_waddr = m_reg[AW-1:0];
        map_wdata = 1'b0;
        rd_addr_a = gpps_pkg::map_addr(i_reg);
        rd_addr_b = gpps_pkg::map_addr(pair_j);
        case (state_reg)
            S_FILL:
            begin
                map_we    = 1'b1;
                map_wdata = (m_reg > (AW+1)'(1));
            end
            S_MARK:
            begin
                map_we = 1'b1;
            end
            S_PREAD:
            begin
                rd_addr_a = p_reg;
            end
            S_IDLE:
            begin
                rd_addr_a = gpps_pkg::map_addr(WW'(q_in) - WW'(2));
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        rd_a_reg <= map_mem[rd_addr_a];
        rd_b_reg <= map_mem[rd_addr_b];
    end

    always_comb
    begin
        state_next     = state_reg;
        m_next         = m_reg;
        p_next         = p_reg;
        psq_next       = psq_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        chk_valid_next = 1'b0;
        chk_i_next     = chk_i_reg;
        res_found_next = res_found_reg;
        res_lo_next    = res_lo_reg;
        res_hi_next    = res_hi_reg;
        case (state_reg)
            S_FILL:
            begin
                m_next = m_reg + (AW+1)'(1);
                if (m_reg == SIZE_C - (AW+1)'(1))
                begin
                    p_next     = AW'(2);
                    psq_next   = (AW+1)'(4);
                    state_next = S_PREAD;
                end
            end
            S_PREAD:
            begin
                // stop once p*p reaches the map end
                state_next = (psq_reg >= SIZE_C) ? S_IDLE : S_PCHK;
            end
            S_PCHK:
            begin
                if (rd_a_reg)
                begin
                    m_next     = psq_reg;
                    state_next = S_MARK;
                end
                else
                begin
                    p_next     = p_reg + AW'(1);
                    psq_next   = psq_reg + {p_reg, 1'b1};
                    state_next = S_PREAD;
                end
            end
            S_MARK:
            begin
                m_next = m_step;
                if (m_step >= SIZE_C)
                begin
                    p_next     = p_reg + AW'(1);
                    psq_next   = psq_reg + {p_reg, 1'b1};
                    state_next = S_PREAD;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    n_next         = q_in;
                    i_next         = start_in;
                    res_found_next = 1'b0;
                    res_lo_next    = '0;
                    res_hi_next    = '0;
                    if (q_in <= VW'(4))
                    begin
                        state_next = S_DONE;
                    end
                    else if (q_in[0])
                    begin
                        state_next = S_ODD;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_ODD:
            begin
                // only 2 + (n-2) can split an odd number
                if (rd_a_reg && gpps_pkg::in_map(odd_idx))
                begin
                    res_found_next = 1'b1;
                    res_lo_next    = VW'(2);
                    res_hi_next    = VW'(odd_idx);
                end
                state_next = S_DONE;
            end
            S_WALK:
            begin
                if (hit)
                begin
                    res_found_next = 1'b1;
                    res_lo_next    = VW'(chk_j);
                    res_hi_next    = VW'(chk_i_reg);
                    state_next     = S_DONE;
                end
                else if (issue)
                begin
                    chk_valid_next = 1'b1;
                    chk_i_next     = i_reg;
                    i_next         = i_reg + WW'(2);
                end
                else
                begin
                    // nothing left in flight: no pair
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_lo_next    = out_lo_reg;
        out_hi_next    = out_hi_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_found_next = res_found_reg;
            out_lo_next    = res_lo_reg;
            out_hi_next    = res_hi_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            m_reg         <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            m_reg         <= m_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        psq_reg       <= psq_next;
        n_reg         <= n_next;
        i_reg         <= i_next;
        chk_i_reg     <= chk_i_next;
        res_found_reg <= res_found_next;
        res_lo_reg    <= res_lo_next;
        res_hi_reg    <= res_hi_next;
        out_found_reg <= out_found_next;
        out_lo_reg    <= out_lo_next;
        out_hi_reg    <= out_hi_next;
    end

    // A found pair is distinct and sums to the query
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_found_reg)
        |-> ((WW'(res_lo_reg) + WW'(res_hi_reg) == n_wide) && (res_lo_reg < res_hi_reg)))
        else $error("found pair does not split the query");

    // No pair means both primes read zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !res_found_reg) |-> (res_lo_reg == '0 && res_hi_reg == '0))
        else $error("not-found result carries primes");

    // The map is written only while the sieve runs
    assert property (@(posedge clk) disable iff (!rst_n)
        map_we |-> (state_reg == S_FILL || state_reg == S_MARK))
        else $error("map write outside sieve");

    // A pending pair check belongs to the walk only
    assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> (state_reg == S_WALK && $past(state_reg) == S_WALK))
        else $error("pair check outside walk");

endmodule
